// ===== rtl/assert_macros.svh =====
// Assertion macros included by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/fdcf_pkg.sv =====
// Shared constants for the fractional delay comb filter.
package fdcf_pkg;

	// Field and register widths
	localparam int SAMPLE_W    = 24;
	localparam int DELAY_W     = 20;
	localparam int FB_W        = 16;
	localparam int FRAC_W      = 8;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 20;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 4'd1;

	// Reset values and limits
	localparam logic [DELAY_W-1:0]    DELAY_RESET = 20'd256;
	localparam int                    DELAY_MIN   = 256;
	localparam logic signed [FB_W-1:0] FB_RESET   = 16'sd0;
	localparam logic signed [FB_W-1:0] FB_LIMIT   = 16'sd32112;

	// Feedback product scaling: 8 interpolation bits plus 15 gain bits
	localparam int SCALE_SHIFT = 23;

endpackage

// ===== rtl/fdcf_ring.sv =====
// Delay ring: one-port-read, one-port-write sample memory with write pointer and fill tracking.
module fdcf_ring #(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	input  logic                          wr_en,
	input  logic [fdcf_pkg::SAMPLE_W-1:0] wr_data,
	output logic [AW-1:0]                 wr_ptr,
	output logic [fdcf_pkg::SAMPLE_W-1:0] rd_data
);
	import fdcf_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [SAMPLE_W-1:0] rd_q;
	logic [AW-1:0]       wr_ptr_q;
	logic                full_q;
	logic                rd_hit_q;

	// Storage: write at the pointer, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Advance the pointer and track which entries hold written samples.
	// Writes go in address order from zero, so below the pointer or after
	// the first wrap an entry is written; otherwise it reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			full_q   <= 1'b0;
			rd_hit_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_hit_q <= full_q || (rd_addr < wr_ptr_q);
			end
			if (wr_en) begin
				if (wr_ptr_q == LAST) begin
					wr_ptr_q <= '0;
					full_q   <= 1'b1;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
		end
	end

	assign wr_ptr  = wr_ptr_q;
	assign rd_data = rd_hit_q ? rd_q : '0;

endmodule

// ===== rtl/fractional_delay_comb_filter_core.sv =====
// Top level of the fractional delay comb filter: config, sequencer and arithmetic.
//
// Feedback comb filter on signed 24-bit audio samples (1.0 = 2^20).
// Input samples arrive on the s_ stream channel, filtered samples leave on
// the m_ stream channel; a request moves when tvalid and tready are high.
// The cfg channel writes register 0 (delay, 8 fraction bits) and
// register 1 (feedback, Q1.15); cfg_ready is always high. Write it only
// while no sample is in flight. Other indexes are dropped.
// Each sample reads two ring entries through the single memory read port,
// one after the other, then interpolates, multiplies by the feedback gain,
// saturates and writes the result back into the ring.
// Each result is registered through the states S_RD0, S_RD1, S_MUL and
// S_OUT; the next sample is taken only once the sequencer is back in idle,
// held off by the two reads of the ring port and the interpolate and gain steps.
// The output register decouples the sides: the next sample is accepted
// while a result waits; a stalled receiver holds the sequencer only at its
// final step, until the output register frees.
// Reset: the ring reads as zero until written (tracked by a fill mark, so
// no clearing pass is needed), the write index is zero, delay is one
// sample and feedback is zero.
`include "assert_macros.svh"

module fractional_delay_comb_filter_core #(
	parameter int MAX_DELAY = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input samples
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fdcf_pkg::SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
	// Output samples
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fdcf_pkg::SAMPLE_W-1:0]   m_tdata,   // [23:0] sample_out
	// Configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fdcf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fdcf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fdcf_pkg::*;

	localparam int AW     = $clog2(MAX_DELAY);
	localparam int CMP_W  = (AW + FRAC_W > DELAY_W) ? AW + FRAC_W : DELAY_W;
	localparam int ACC_W  = SAMPLE_W + FRAC_W;
	localparam int IW     = ACC_W + 2;
	localparam int PROD_W = ACC_W + FB_W;
	localparam int FBK_W  = PROD_W - SCALE_SHIFT;
	localparam int SUM_W  = ((FBK_W > SAMPLE_W) ? FBK_W : SAMPLE_W) + 1;

	localparam logic [AW:0]        DEPTH_W = (AW + 1)'(MAX_DELAY);
	localparam logic [AW-1:0]      LAST    = AW'(MAX_DELAY - 1);
	localparam logic [CMP_W-1:0]   D_MIN   = CMP_W'(DELAY_MIN);
	localparam logic [CMP_W-1:0]   D_MAX   = CMP_W'((MAX_DELAY - 1) * (2 ** FRAC_W));
	localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1) <<< (SCALE_SHIFT - 1);
	localparam logic signed [SUM_W-1:0]  SAT_HI = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0]  SAT_LO = -SAT_HI - 1;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD0  = 3'd1;
	localparam logic [2:0] S_RD1  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]                state_q;
	logic [DELAY_W-1:0]        delay_q;
	logic signed [FB_W-1:0]    fb_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic [AW-1:0]             r1_q;
	logic signed [SAMPLE_W-1:0] v0_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      out_valid_q;
	logic [SAMPLE_W-1:0]       out_q;

	logic                      in_req;
	logic                      out_free;
	logic                      ring_rd_en;
	logic [AW-1:0]             ring_rd_addr;
	logic                      ring_wr_en;
	logic [AW-1:0]             wp;
	logic [SAMPLE_W-1:0]       ring_rd;
	logic [CMP_W-1:0]          d_ext;
	logic [CMP_W-1:0]          d_clamp;
	logic [AW-1:0]             di;
	logic [FRAC_W-1:0]         frac;
	logic signed [FB_W-1:0]    fb_clamp;
	logic [AW:0]               diff0;
	logic [AW:0]               diff0_wrap;
	logic [AW-1:0]             r0;
	logic [AW-1:0]             r1;
	logic signed [SAMPLE_W:0]  slope;
	logic signed [IW-1:0]      base;
	logic signed [IW-1:0]      interp;
	logic signed [PROD_W-1:0]  rnd;
	logic signed [FBK_W-1:0]   fbk;
	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   y_sat;
	logic [SAMPLE_W-1:0]       y;

	assign in_req    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	// Clamp delay and feedback to their usable ranges
	always_comb begin
		d_ext = CMP_W'(delay_q);
		priority if (d_ext < D_MIN) begin
			d_clamp = D_MIN;
		end else if (d_ext > D_MAX) begin
			d_clamp = D_MAX;
		end else begin
			d_clamp = d_ext;
		end
		priority if (fb_q > FB_LIMIT) begin
			fb_clamp = FB_LIMIT;
		end else if (fb_q < -FB_LIMIT) begin
			fb_clamp = -FB_LIMIT;
		end else begin
			fb_clamp = fb_q;
		end
	end

	assign di   = d_clamp[AW+FRAC_W-1:FRAC_W];
	assign frac = d_clamp[FRAC_W-1:0];

	// Tap addresses: integer delay behind the write index, and one older
	assign diff0      = {1'b0, wp} - {1'b0, di};
	assign diff0_wrap = diff0 + DEPTH_W;
	assign r0         = diff0[AW] ? diff0_wrap[AW-1:0] : diff0[AW-1:0];
	assign r1         = (r0 == '0) ? LAST : r0 - 1'b1;

	// Ring port: first tap on accept, second tap in the next cycle (S_RD0)
	assign ring_rd_en   = in_req || (state_q == S_RD0);
	assign ring_rd_addr = (state_q == S_RD0) ? r1_q : r0;
	assign ring_wr_en   = (state_q == S_OUT) && out_free;

	// Interpolate as v0*256 + (v1 - v0)*frac
	always_comb begin
		slope  = $signed({ring_rd[SAMPLE_W-1], ring_rd}) - $signed({v0_q[SAMPLE_W-1], v0_q});
		base   = $signed({{2{v0_q[SAMPLE_W-1]}}, v0_q, {FRAC_W{1'b0}}});
		interp = base + slope * $signed({1'b0, frac});
	end

	// Round the gain product half up, add the input and saturate
	always_comb begin
		rnd = prod_q + ROUND;
		fbk = rnd[PROD_W-1:SCALE_SHIFT];
		sum = SUM_W'(x_q) + SUM_W'(fbk);
		priority if (sum > SAT_HI) begin
			y_sat = SAT_HI;
		end else if (sum < SAT_LO) begin
			y_sat = SAT_LO;
		end else begin
			y_sat = sum;
		end
		y = y_sat[SAMPLE_W-1:0];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			fb_q    <= FB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DELAY: begin
					delay_q <= cfg_data[DELAY_W-1:0];
				end
				REG_FEEDBACK: begin
					fb_q <= $signed(cfg_data[FB_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_req) begin
						state_q <= S_RD0;
					end
				end
				S_RD0: begin
					state_q <= S_RD1;
				end
				S_RD1: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_req) begin
			x_q  <= $signed(s_tdata);
			r1_q <= r1;
		end
		if (state_q == S_RD0) begin
			v0_q <= $signed(ring_rd);
		end
		if (state_q == S_RD1) begin
			acc_q <= interp[ACC_W-1:0];
		end
		if (state_q == S_MUL) begin
			prod_q <= acc_q * fb_clamp;
		end
		if (ring_wr_en) begin
			out_q <= y;
		end
	end

	fdcf_ring #(
		.DEPTH (MAX_DELAY)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ring_rd_en),
		.rd_addr (ring_rd_addr),
		.wr_en   (ring_wr_en),
		.wr_data (y),
		.wr_ptr  (wp),
		.rd_data (ring_rd)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// One sample in flight: an accepted request closes the input side
	`ASSERT_CLK(a_one_in_flight, clk, arst_n, in_req |=> !s_tready, "second request taken while busy")
	// A ring write always lands a result in a free output register
	`ASSERT_CLK(a_wr_out_free, clk, arst_n, ring_wr_en |-> out_free, "result written over a waiting output")
	// Each ring write moves the write index on
	`ASSERT_CLK(a_wp_advance, clk, arst_n, ring_wr_en |=> (wp != $past(wp)), "write index did not advance")
	// The clamped integer delay never points at the write index
	`ASSERT_CLK(a_tap_behind, clk, arst_n, in_req |-> (r0 != wp), "first tap equals write index")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the fractional delay comb filter core.
module tb;
	import fdcf_pkg::*;

	localparam int RING_DEPTH  = 4096;
	localparam int DELAY_TOP   = (RING_DEPTH - 1) * 256;
	localparam int SAMPLE_MAX  = (1 << (SAMPLE_W - 1)) - 1;
	localparam int SAMPLE_MIN  = -(1 << (SAMPLE_W - 1));
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;
	localparam int SET_ITEMS   = 50;

	localparam logic [SAMPLE_W-1:0] TOP_SAMPLE    = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] BOTTOM_SAMPLE = {1'b1, {(SAMPLE_W - 1){1'b0}}};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [SAMPLE_W-1:0]   m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Filter model state
	logic signed [SAMPLE_W-1:0] ring_model [RING_DEPTH];
	int                         wr_model = 0;
	logic [DELAY_W-1:0]         delay_model = DELAY_RESET;
	logic [FB_W-1:0]            gain_model = FB_RESET;

	// Samples waiting to go in, filtered samples waiting to come out
	logic [SAMPLE_W-1:0] samples_to_send [$];
	logic [SAMPLE_W-1:0] filtered_q [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit offer_up       = 1'b0;
	bit rx_hold        = 1'b0;
	bit hold_arm       = 1'b0;
	int n_sent         = 0;
	int n_checked      = 0;
	int n_errors       = 0;
	int n_settings     = 0;
	int cycle_count    = 0;

	fractional_delay_comb_filter_core #(
		.MAX_DELAY(RING_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),      // [23:0] sample_in
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),      // [23:0] sample_out
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Run one sample through the comb filter model and return the filtered sample
	function automatic logic [SAMPLE_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] x);
		longint d, di, df, g, acc, fbk, sum;
		int     r0, r1;
		d = longint'(delay_model);
		if (d < DELAY_MIN) d = DELAY_MIN;
		if (d > DELAY_TOP) d = DELAY_TOP;
		di = d >>> FRAC_W;
		df = d % 256;
		g = longint'($signed(gain_model));
		if (g > longint'(FB_LIMIT)) g = longint'(FB_LIMIT);
		if (g < -longint'(FB_LIMIT)) g = -longint'(FB_LIMIT);
		r0 = (wr_model + RING_DEPTH - int'(di)) % RING_DEPTH;
		r1 = (r0 + RING_DEPTH - 1) % RING_DEPTH;
		acc = longint'(ring_model[r0]) * (256 - df) + longint'(ring_model[r1]) * df;
		// round half up, floor on the arithmetic shift
		fbk = (acc * g + (longint'(1) <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
		sum = longint'($signed(x)) + fbk;
		if (sum > SAMPLE_MAX) sum = SAMPLE_MAX;
		if (sum < SAMPLE_MIN) sum = SAMPLE_MIN;
		ring_model[wr_model] = sum[SAMPLE_W-1:0];
		wr_model = (wr_model + 1) % RING_DEPTH;
		return sum[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		int v;
		case ($urandom_range(5))
			0: v = int'($urandom);
			1: v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
			2: v = int'($urandom_range(1 << 21)) - (1 << 20);
			default: v = int'($urandom_range(1 << 23)) - (1 << 22);
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	// Drive the input side: change at the falling edge, hold a request until taken
	always @(negedge clk) begin
		if (!offer_up && arst_n && samples_to_send.size() > 0
				&& $urandom_range(99) >= send_idle_pct) begin
			s_tvalid <= 1'b1;
			s_tdata <= samples_to_send[0];
			offer_up = 1'b1;
		end else if (!offer_up) begin
			s_tvalid <= 1'b0;
			s_tdata <= SAMPLE_W'($urandom);
		end
		m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// Watch all three channels at the rising edge
	always @(posedge clk) begin : monitor
		logic [SAMPLE_W-1:0] want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DELAY: delay_model = cfg_data[DELAY_W-1:0];
					REG_FEEDBACK: gain_model = cfg_data[FB_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				filtered_q.push_back(filter_sample(s_tdata));
				void'(samples_to_send.pop_front());
				offer_up = 1'b0;
				n_sent++;
			end
			if (m_tvalid && m_tready) begin
				if (filtered_q.size() == 0) begin
					n_errors++;
					if (n_errors <= REPORT_MAX)
						$display("unexpected output %h with no sample pending", m_tdata);
				end else begin
					want = filtered_q.pop_front();
					if (m_tdata !== want) begin
						n_errors++;
						if (n_errors <= REPORT_MAX)
							$display("output %0d: expected %h got %h", n_checked, want, m_tdata);
					end
					n_checked++;
				end
			end
		end
	end

	// Long receiver hold-off, counted here once armed
	initial begin : rx_hold_gen
		wait (hold_arm);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outputs pending", cycle_count,
				filtered_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// Wait until every queued sample went in and every output came back
	task automatic wait_idle();
		while (samples_to_send.size() != 0 || offer_up || filtered_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data <= CFG_DATA_W'($urandom);
	endtask

	// Pick a delay and gain, mostly short delays so the feedback path stays busy
	task automatic random_filter();
		logic [DELAY_W-1:0]    dly;
		logic [CFG_DATA_W-1:0] gain_word;
		int                    gi;
		case ($urandom_range(9))
			0: dly = DELAY_W'($urandom_range(DELAY_MIN - 1));
			1: dly = DELAY_W'($urandom_range((1 << DELAY_W) - 1, DELAY_TOP));
			2: dly = DELAY_W'($urandom);
			default: dly = DELAY_W'($urandom_range(48 * 256, DELAY_MIN));
		endcase
		case ($urandom_range(4))
			0: gi = int'($urandom_range((1 << FB_W) - 1));
			1: gi = int'(FB_LIMIT) - int'($urandom_range(200));
			2: gi = int'($urandom_range(200)) - int'(FB_LIMIT);
			default: gi = int'($urandom_range(2 * int'(FB_LIMIT))) - int'(FB_LIMIT);
		endcase
		gain_word = CFG_DATA_W'($urandom);
		gain_word[FB_W-1:0] = gi[FB_W-1:0];
		write_reg(REG_DELAY, dly);
		write_reg(REG_FEEDBACK, gain_word);
		// stray write to an unused index now and then
		if ($urandom_range(2) == 0)
			write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_FEEDBACK + 1)),
				CFG_DATA_W'($urandom));
		n_settings++;
	endtask

	initial begin
		for (int i = 0; i < RING_DEPTH; i++)
			ring_model[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: one sample delay, zero gain, output follows input
		n_settings++;
		samples_to_send.push_back('0);
		samples_to_send.push_back(TOP_SAMPLE);
		samples_to_send.push_back(BOTTOM_SAMPLE);
		samples_to_send.push_back('1);
		samples_to_send.push_back(SAMPLE_W'(1));
		samples_to_send.push_back(24'h555555);
		samples_to_send.push_back(24'hAAAAAA);
		wait_idle();

		// Gain above the limit with a one-and-a-half-sample delay; drive into positive saturation
		write_reg(REG_DELAY, CFG_DATA_W'(20'h00180));
		write_reg(REG_FEEDBACK, CFG_DATA_W'(16'h7FFF));
		n_settings++;
		repeat (3) samples_to_send.push_back(TOP_SAMPLE);
		samples_to_send.push_back(SAMPLE_W'(1 << 20));
		samples_to_send.push_back(SAMPLE_W'(-(1 << 20)));
		samples_to_send.push_back('0);
		wait_idle();

		// Zero delay and most negative gain
		write_reg(REG_DELAY, '0);
		write_reg(REG_FEEDBACK, {4'hF, 16'h8000});
		n_settings++;
		repeat (2) samples_to_send.push_back(BOTTOM_SAMPLE);
		repeat (2) samples_to_send.push_back(TOP_SAMPLE);
		samples_to_send.push_back('0);
		wait_idle();

		// Delay past the top of the ring, gain exactly at the limit
		write_reg(REG_DELAY, '1);
		write_reg(REG_FEEDBACK, CFG_DATA_W'(FB_LIMIT));
		n_settings++;
		repeat (3) samples_to_send.push_back(random_sample());
		wait_idle();

		// Delay exactly at the top, negative limit gain, ignored writes
		write_reg(REG_DELAY, CFG_DATA_W'(DELAY_TOP));
		write_reg(REG_FEEDBACK, CFG_DATA_W'(-FB_LIMIT));
		write_reg('1, '1);
		write_reg(CFG_IDX_W'(1 << (CFG_IDX_W - 1)), '1);
		n_settings++;
		repeat (3) samples_to_send.push_back(random_sample());
		wait_idle();

		// Random part under each idle pattern
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int s = 0; s < 2; s++) begin
				random_filter();
				if (mode == 0 && s == 0) begin
					@(posedge clk);
					hold_arm = 1'b1;
				end
				repeat (SET_ITEMS) samples_to_send.push_back(random_sample());
				wait_idle();
			end
		end

		repeat (20) @(posedge clk);
		$display("Sent %0d samples over %0d delay/gain settings with clamps, saturation,",
			n_sent, n_settings);
		$display("idle gaps and a long output stall; %0d outputs checked, %0d failures",
			n_checked, n_errors);
		if (n_errors == 0 && filtered_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fdcf_pkg.sv
rtl/fdcf_ring.sv
rtl/fractional_delay_comb_filter_core.sv
tb/tb.sv
